// File: design/gnb_pkg.sv
// gnb_pkg: shared types, request codes, state encodings and saturating helpers
// for the group normalization backward engine; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gnb_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int RECIP_SHIFT = 31;
    localparam int GRP_DEPTH   = 64;
    localparam int CH_DEPTH    = 64;
    localparam int GRP_AW      = $clog2(GRP_DEPTH);
    localparam int CH_AW       = $clog2(CH_DEPTH);

    typedef logic signed [47:0] t_q48;
    typedef logic signed [31:0] t_q32;

    localparam t_q48 SAT_HI = 48'sh7FFF_FFFF_FFFF;
    localparam t_q48 SAT_LO = 48'sh8000_0000_0000;

    // request codes
    typedef enum logic [2:0] {
        REQ_BEGIN  = 3'd0,
        REQ_STATS  = 3'd1,
        REQ_GAMMA  = 3'd2,
        REQ_PASS1  = 3'd3,
        REQ_PASS2  = 3'd4,
        REQ_RD_CH  = 3'd5,
        REQ_RD_GRP = 3'd6,
        REQ_NONE   = 3'd7
    } t_req;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DX  = 2'd0,
        KIND_CH  = 2'd1,
        KIND_GRP = 2'd2
    } t_kind;

    // configuration register indexes
    localparam logic [2:0] CFG_BATCH  = 3'd0;
    localparam logic [2:0] CFG_GROUPS = 3'd1;
    localparam logic [2:0] CFG_CPG    = 3'd2;
    localparam logic [2:0] CFG_SPAT   = 3'd3;
    localparam logic [2:0] CFG_LAYOUT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_RECIP = 3'd1,
        ST_READ  = 3'd2,
        ST_CALC  = 3'd3,
        ST_WRITE = 3'd4,
        ST_OUT   = 3'd5
    } t_state;

    // access request into the table store
    typedef struct packed {
        logic              re;
        logic [GRP_AW-1:0] g_addr;
        logic [CH_AW-1:0]  c_addr;
        logic              stat_we;
        logic              gsum_we;
        logic              gam_we;
        logic              csum_we;
        logic              clear;
        t_q32              mean;
        t_q32              inv;
        t_q48              ds;
        t_q48              db;
        t_q32              gamma;
        t_q48              dg;
        t_q48              dbeta;
    } t_store_req;

    // registered read data from the table store
    typedef struct packed {
        t_q32 mean;
        t_q32 inv;
        t_q48 ds;
        t_q48 db;
        t_q32 gamma;
        t_q48 dg;
        t_q48 dbeta;
    } t_store_rd;

    // saturating 48-bit add or subtract
    function automatic t_q48 sat_add(input t_q48 a, input t_q48 b, input logic sub);
        logic signed [48:0] s;
        s = sub ? ({a[47], a} - {b[47], b}) : ({a[47], a} + {b[47], b});
        if (s[48] != s[47]) begin
            return s[48] ? SAT_LO : SAT_HI;
        end
        return s[47:0];
    endfunction

    function automatic t_q48 sext32(input t_q32 v);
        return {{16{v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

// File: design/gnb_mul.sv
// gnb_mul: shared sequential 48x48 signed multiplier, four 24x24 partials,
// truncating right shift and 48-bit saturation; uses gnb_pkg
`timescale 1ns / 1ps
`default_nettype none

module gnb_mul
    import gnb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_q48 i_a,
    input  wire t_q48 i_b,
    input  wire logic i_long,
    output logic      o_done,
    output t_q48      o_p
);

    logic [47:0] r_ua, r_ub;
    logic        r_neg, r_long, r_busy, r_done;
    logic [2:0]  r_cnt;
    logic [95:0] r_acc;
    t_q48        r_p;

    logic [23:0] pa, pb;
    logic [47:0] prod;
    logic [95:0] part, shr;
    logic        big;
    t_q48        fin;

    // one partial product per cycle
    always_comb begin
        pa   = r_cnt[0] ? r_ua[47:24] : r_ua[23:0];
        pb   = r_cnt[1] ? r_ub[47:24] : r_ub[23:0];
        prod = pa * pb;
        case (r_cnt[1:0])
            2'd0:    part = {48'd0, prod};
            2'd3:    part = {prod, 48'd0};
            default: part = {24'd0, prod, 24'd0};
        endcase
    end

    // shift magnitude, apply sign and saturate
    always_comb begin
        shr = r_long ? (r_acc >> RECIP_SHIFT) : (r_acc >> FRAC_BITS);
        if (r_neg) begin
            big = (|shr[95:48]) || (shr[47] && (|shr[46:0]));
            fin = big ? SAT_LO : t_q48'(48'd0 - shr[47:0]);
        end else begin
            big = |shr[95:47];
            fin = big ? SAT_HI : t_q48'(shr[47:0]);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua   <= i_a[47] ? (48'd0 - i_a) : i_a;
            r_ub   <= i_b[47] ? (48'd0 - i_b) : i_b;
            r_neg  <= i_a[47] ^ i_b[47];
            r_long <= i_long;
            r_acc  <= 96'd0;
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                r_p <= fin;
            end else begin
                r_acc <= r_acc + part;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

`default_nettype wire

// File: design/gnb_recip.sv
// gnb_recip: restoring divider forming round(2^31 / (D*S)), one quotient bit
// per cycle; uses gnb_pkg
`timescale 1ns / 1ps
`default_nettype none

module gnb_recip
    import gnb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [18:0] i_div,
    output logic             o_done,
    output logic [31:0]      o_quot
);

    logic [31:0] r_num, r_q;
    logic [18:0] r_rem, r_dv;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;

    logic [19:0] trial;
    logic        qbit;
    logic [18:0] n_rem;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_num[31]};
        qbit  = (trial >= {1'b0, r_dv});
        n_rem = qbit ? 19'(trial - {1'b0, r_dv}) : trial[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= 32'h8000_0000 + {14'd0, i_div[18:1]};
            r_rem <= 19'd0;
            r_dv  <= i_div;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= n_rem;
            r_q   <= {r_q[30:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: design/gnb_store.sv
// gnb_store: group memory {mean, inverse deviation, ds, db} and channel memory
// {gamma, dgamma, dbeta}, registered reads, valid bits on the sums; uses gnb_pkg
`timescale 1ns / 1ps
`default_nettype none

module gnb_store
    import gnb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_store_req i_req,
    output t_store_rd       o_rd
);

    logic [159:0]         r_grp_mem [GRP_DEPTH];
    logic [127:0]         r_ch_mem  [CH_DEPTH];
    logic [GRP_DEPTH-1:0] r_gv;
    logic [CH_DEPTH-1:0]  r_cv;
    logic [159:0]         r_grp_rd;
    logic [127:0]         r_ch_rd;
    logic                 r_grp_rd_v, r_ch_rd_v;

    // group memory
    always_ff @(posedge i_clk) begin
        if (i_req.stat_we) begin
            r_grp_mem[i_req.g_addr][159:96] <= {i_req.mean, i_req.inv};
        end
        if (i_req.gsum_we) begin
            r_grp_mem[i_req.g_addr][95:0] <= {i_req.ds, i_req.db};
        end
        if (i_req.re) begin
            r_grp_rd <= r_grp_mem[i_req.g_addr];
        end
    end

    // channel memory
    always_ff @(posedge i_clk) begin
        if (i_req.gam_we) begin
            r_ch_mem[i_req.c_addr][127:96] <= i_req.gamma;
        end
        if (i_req.csum_we) begin
            r_ch_mem[i_req.c_addr][95:0] <= {i_req.dg, i_req.dbeta};
        end
        if (i_req.re) begin
            r_ch_rd <= r_ch_mem[i_req.c_addr];
        end
    end

    // sum valid bits, cleared by reset and by begin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_gv <= '0;
            r_cv <= '0;
        end else begin
            if (i_req.gsum_we) begin
                r_gv[i_req.g_addr] <= 1'b1;
            end
            if (i_req.csum_we) begin
                r_cv[i_req.c_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_grp_rd_v <= r_gv[i_req.g_addr];
            r_ch_rd_v  <= r_cv[i_req.c_addr];
        end
    end

    // unwritten sums read as zero
    always_comb begin
        o_rd.mean  = r_grp_rd[159:128];
        o_rd.inv   = r_grp_rd[127:96];
        o_rd.ds    = r_grp_rd_v ? t_q48'(r_grp_rd[95:48]) : t_q48'(48'd0);
        o_rd.db    = r_grp_rd_v ? t_q48'(r_grp_rd[47:0]) : t_q48'(48'd0);
        o_rd.gamma = r_ch_rd[127:96];
        o_rd.dg    = r_ch_rd_v ? t_q48'(r_ch_rd[95:48]) : t_q48'(48'd0);
        o_rd.dbeta = r_ch_rd_v ? t_q48'(r_ch_rd[47:0]) : t_q48'(48'd0);
    end

endmodule

`default_nettype wire

// File: design/group_norm_backward_top.sv
// group_norm_backward_top: request sequencer, position counter and datapath
// of the group normalization backward engine; uses gnb_pkg, gnb_mul, gnb_recip, gnb_store
//
//   channel   signals                                           dir
//   request   i_in_valid/o_in_ready, req_type, index, a, b      in
//   result    o_out_valid/i_out_ready, kind, result_a/b         out
//   config    i_cfg_we, i_cfg_index, i_cfg_data                 in
//
// one request at a time. begin runs the bit-serial reciprocal divider. the
// multiplies share one multiplier: pass one needs 2, pass two 11. a result
// waits in the output register while the next request is taken; a held
// output stalls the next result, and no request is taken while that result
// waits. no clearing pass after reset: the sum tables carry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module group_norm_backward_top
    import gnb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [5:0]  i_entry_index,
    input  wire logic [31:0] i_value_a,
    input  wire logic [31:0] i_value_b,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_kind,
    output logic [47:0]      o_result_a,
    output logic [47:0]      o_result_b,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);

    typedef enum logic [1:0] {
        DST_T1   = 2'd0,
        DST_T2   = 2'd1,
        DST_R3   = 2'd2,
        DST_TERM = 2'd3
    } t_dst;

    localparam logic [3:0] LAST_P1 = 4'd1;
    localparam logic [3:0] LAST_P2 = 4'd10;

    // configuration registers
    logic [4:0]  r_batch;
    logic [6:0]  r_groups, r_cpg;
    logic [12:0] r_spat;
    logic        r_layout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch  <= 5'd1;
            r_groups <= 7'd1;
            r_cpg    <= 7'd1;
            r_spat   <= 13'd1;
            r_layout <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BATCH:  r_batch  <= i_cfg_data[4:0];
                CFG_GROUPS: r_groups <= i_cfg_data[6:0];
                CFG_CPG:    r_cpg    <= i_cfg_data[6:0];
                CFG_SPAT:   r_spat   <= i_cfg_data;
                CFG_LAYOUT: r_layout <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped dimensions
    logic [4:0]  dim_n;
    logic [6:0]  dim_g, dim_d;
    logic [12:0] dim_s;
    logic [19:0] dxs;

    always_comb begin
        dim_n = (r_batch == 5'd0) ? 5'd1 : ((r_batch > 5'd16) ? 5'd16 : r_batch);
        dim_g = (r_groups == 7'd0) ? 7'd1 : ((r_groups > 7'd64) ? 7'd64 : r_groups);
        dim_d = (r_cpg == 7'd0) ? 7'd1 : ((r_cpg > 7'd64) ? 7'd64 : r_cpg);
        dim_s = (r_spat == 13'd0) ? 13'd1 : ((r_spat > 13'd4096) ? 13'd4096 : r_spat);
        dxs   = dim_d * dim_s;
    end

    // registers of the sequencer
    t_state      r_state, n_state;
    logic [11:0] r_dig [4];
    logic [11:0] n_dig [4];
    logic        r_p2, r_wait;
    logic [3:0]  r_step;
    t_kind       r_kind;
    logic [GRP_AW-1:0] r_gi;
    logic [CH_AW-1:0]  r_ci;
    t_q32        r_a, r_b;
    t_q48        r_t1, r_t2, r_r3, r_term;
    logic [31:0] r_recip;
    logic        r_ovalid;
    t_kind       r_okind;
    t_q48        r_oa, r_ob;

    // position counter: table indexes and next digits
    logic [12:0] dim [4];
    logic [11:0] gprod, cprod;
    logic [6:0]  gsum, csum;
    logic [GRP_AW-1:0] cur_gi;
    logic [CH_AW-1:0]  cur_ci;
    logic        carry;
    logic [12:0] inc;

    always_comb begin
        dim[0] = {8'd0, dim_n};
        if (!r_layout) begin
            dim[1] = {6'd0, dim_g};
            dim[2] = {6'd0, dim_d};
            dim[3] = dim_s;
            gprod  = r_dig[0][5:0] * dim_g[5:0];
            gsum   = gprod[5:0] + r_dig[1][5:0];
            cprod  = r_dig[1][5:0] * dim_d[5:0];
            csum   = cprod[5:0] + r_dig[2][5:0];
        end else begin
            dim[1] = dim_s;
            dim[2] = {6'd0, dim_g};
            dim[3] = {6'd0, dim_d};
            gprod  = r_dig[0][5:0] * dim_g[5:0];
            gsum   = gprod[5:0] + r_dig[2][5:0];
            cprod  = r_dig[2][5:0] * dim_d[5:0];
            csum   = cprod[5:0] + r_dig[3][5:0];
        end
        cur_gi = gsum[GRP_AW-1:0];
        cur_ci = csum[CH_AW-1:0];
        carry  = 1'b1;
        inc    = 13'd0;
        for (int k = 3; k >= 0; k--) begin
            n_dig[k] = r_dig[k];
            if (carry) begin
                inc = {1'b0, r_dig[k]} + 13'd1;
                if (inc < dim[k]) begin
                    n_dig[k] = inc[11:0];
                    carry    = 1'b0;
                end else begin
                    n_dig[k] = 12'd0;
                end
            end
        end
    end

    // units
    t_store_req st_req;
    t_store_rd  st_rd;
    logic       mul_start, mul_long, mul_done;
    t_q48       mul_a, mul_b, mul_p;
    logic       div_start, div_done;
    logic [31:0] div_quot;

    gnb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (st_req),
        .o_rd    (st_rd)
    );

    gnb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_long  (mul_long),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    gnb_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_div   (dxs[18:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // operand selection per step
    t_q48 xm, tdiff, wdiff;
    t_dst dst;

    always_comb begin
        xm       = sat_add(sext32(r_a), sext32(st_rd.mean), 1'b1);
        tdiff    = sat_add(r_t1, st_rd.ds, 1'b1);
        wdiff    = sat_add(r_t1, r_t2, 1'b1);
        mul_long = 1'b0;
        mul_a    = sext32(st_rd.gamma);
        mul_b    = sext32(r_b);
        dst      = DST_T1;
        if (!r_p2) begin
            case (r_step)
                4'd0:    dst = DST_T2;
                default: begin
                    mul_a = r_t2;
                    mul_b = sext32(r_a);
                end
            endcase
        end else begin
            case (r_step)
                4'd0: begin
                    mul_a = sext32(st_rd.inv);
                    mul_b = sext32(st_rd.inv);
                end
                4'd1: begin
                    mul_a = r_t1;
                    mul_b = sext32(st_rd.inv);
                    dst   = DST_R3;
                end
                4'd2: begin
                    mul_a = st_rd.db;
                    mul_b = sext32(st_rd.mean);
                end
                4'd3: begin
                    mul_a = tdiff;
                    mul_b = xm;
                end
                4'd4: begin
                    mul_a = r_t1;
                    mul_b = r_r3;
                end
                4'd5: begin
                    mul_a = st_rd.db;
                    mul_b = sext32(st_rd.inv);
                    dst   = DST_T2;
                end
                4'd6: begin
                    mul_a    = wdiff;
                    mul_b    = {16'd0, r_recip};
                    mul_long = 1'b1;
                    dst      = DST_TERM;
                end
                4'd7: ;
                4'd8: begin
                    mul_a = r_t1;
                    mul_b = sext32(st_rd.inv);
                end
                4'd9: begin
                    mul_a = sext32(r_b);
                    mul_b = xm;
                    dst   = DST_T2;
                end
                default: begin
                    mul_a = r_t2;
                    mul_b = sext32(st_rd.inv);
                    dst   = DST_T2;
                end
            endcase
        end
    end

    // request decode and next state
    logic accept;
    t_req req;
    logic out_free;

    always_comb begin
        req        = t_req'(i_req_type);
        o_in_ready = (r_state == ST_IDLE);
        accept     = i_in_valid && o_in_ready;
        out_free   = !r_ovalid || i_out_ready;
        n_state    = r_state;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        st_req         = '0;
        st_req.g_addr  = i_entry_index[GRP_AW-1:0];
        st_req.c_addr  = i_entry_index[CH_AW-1:0];
        st_req.mean    = i_value_a;
        st_req.inv     = i_value_b;
        st_req.gamma   = i_value_a;
        st_req.ds      = sat_add(st_rd.ds, r_t1, 1'b0);
        st_req.db      = sat_add(st_rd.db, r_t2, 1'b0);
        st_req.dg      = sat_add(st_rd.dg, r_t2, 1'b0);
        st_req.dbeta   = sat_add(st_rd.dbeta, sext32(r_b), 1'b0);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_BEGIN: begin
                            st_req.clear = 1'b1;
                            div_start    = 1'b1;
                            n_state      = ST_RECIP;
                        end
                        REQ_STATS: st_req.stat_we = 1'b1;
                        REQ_GAMMA: st_req.gam_we  = 1'b1;
                        REQ_PASS1, REQ_PASS2: begin
                            st_req.re     = 1'b1;
                            st_req.g_addr = cur_gi;
                            st_req.c_addr = cur_ci;
                            n_state       = ST_READ;
                        end
                        REQ_RD_CH, REQ_RD_GRP: begin
                            st_req.re = 1'b1;
                            n_state   = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RECIP: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = (r_kind == KIND_DX) ? ST_CALC : ST_OUT;
            end
            ST_CALC: begin
                if (!r_wait) begin
                    mul_start = 1'b1;
                end else if (mul_done && (r_step == (r_p2 ? LAST_P2 : LAST_P1))) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                st_req.g_addr  = r_gi;
                st_req.c_addr  = r_ci;
                st_req.gsum_we = !r_p2;
                st_req.csum_we = r_p2;
                n_state        = r_p2 ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_dig    <= '{default: 12'd0};
            r_recip  <= 32'd0;
            r_wait   <= 1'b0;
            r_step   <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && req == REQ_BEGIN) begin
                r_dig <= '{default: 12'd0};
            end else if (accept && (req == REQ_PASS1 || req == REQ_PASS2)) begin
                r_dig <= n_dig;
            end
            if (r_state == ST_RECIP && div_done) begin
                r_recip <= div_quot;
            end
            if (r_state == ST_READ) begin
                r_step <= 4'd0;
                r_wait <= 1'b0;
            end else if (r_state == ST_CALC) begin
                if (!r_wait) begin
                    r_wait <= 1'b1;
                end else if (mul_done) begin
                    r_wait <= 1'b0;
                    r_step <= r_step + 4'd1;
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // request payload, multiply results and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a  <= i_value_a;
            r_b  <= i_value_b;
            r_gi <= cur_gi;
            r_ci <= cur_ci;
            r_p2 <= (req == REQ_PASS2);
            case (req)
                REQ_RD_CH:  r_kind <= KIND_CH;
                REQ_RD_GRP: r_kind <= KIND_GRP;
                default:    r_kind <= KIND_DX;
            endcase
        end
        if (r_state == ST_CALC && r_wait && mul_done) begin
            case (dst)
                DST_T1:   r_t1   <= mul_p;
                DST_T2:   r_t2   <= mul_p;
                DST_R3:   r_r3   <= mul_p;
                default:  r_term <= mul_p;
            endcase
        end
        if (r_state == ST_OUT && out_free) begin
            r_okind <= r_kind;
            case (r_kind)
                KIND_CH: begin
                    r_oa <= st_rd.dg;
                    r_ob <= st_rd.dbeta;
                end
                KIND_GRP: begin
                    r_oa <= st_rd.ds;
                    r_ob <= st_rd.db;
                end
                default: begin
                    r_oa <= sat_add(r_t1, r_term, 1'b0);
                    r_ob <= '0;
                end
            endcase
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_result_a    = r_oa;
    assign o_result_b    = r_ob;

endmodule

`default_nettype wire
